// ----- rtl/drtfl_pkg.sv -----
`default_nettype none

package drtfl_pkg;

    localparam int YEAR_W   = 14;
    localparam int MD_W     = 7;
    localparam int KEY_W    = 23;
    localparam int RATE_W   = 48;
    localparam int HALF_W   = RATE_W / 2;
    localparam int AMT_W    = 32;
    localparam int PART_W   = AMT_W - 1 + HALF_W;
    localparam int PROD_W   = 58;
    localparam int STATUS_W = 3;

    localparam int YEAR_MAX          = 9999;
    localparam int MONTH_MIN         = 1;
    localparam int MONTH_MAX         = 12;
    localparam int DAY_MIN           = 1;
    localparam int DAYS_LONG         = 31;
    localparam int DAYS_SHORT        = 30;
    localparam int DAYS_FEB          = 28;
    localparam int DAYS_FEB_LEAP     = 29;
    localparam int AMOUNT_LIMIT_INT  = 1000;

    // Division by 100 through a reciprocal: q = (y * 5243) >> 19 is exact for
    // every 14-bit year, and the low 19 bits stay below 5243 only when y is a
    // multiple of 100.
    localparam int DIV100_MUL   = 5243;
    localparam int DIV100_SHIFT = 19;
    localparam int DIV100_W     = YEAR_W + 13;

    localparam logic [MD_W-1:0] MONTH_FEB = 7'd2;
    localparam logic [MD_W-1:0] MONTH_APR = 7'd4;
    localparam logic [MD_W-1:0] MONTH_JUN = 7'd6;
    localparam logic [MD_W-1:0] MONTH_SEP = 7'd9;
    localparam logic [MD_W-1:0] MONTH_NOV = 7'd11;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_CONVERTED = 3'd0,
        ST_STORED    = 3'd1,
        ST_BAD_DATE  = 3'd2,
        ST_NEGATIVE  = 3'd3,
        ST_TOO_LARGE = 3'd4,
        ST_NO_RATE   = 3'd5,
        ST_DUPLICATE = 3'd6,
        ST_FULL      = 3'd7
    } status_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [RATE_W-1:0] rate;
        logic              insert;
        logic              lookup;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/drtfl_date_chk.sv -----
`default_nettype none

module drtfl_date_chk
    import drtfl_pkg::*;
(
    input  logic [YEAR_W-1:0] year,
    input  logic [MD_W-1:0]   month,
    input  logic [MD_W-1:0]   day,
    output logic              ok
);

    logic [DIV100_W-1:0] recip;
    logic                century;
    logic                leap;
    logic [MD_W-1:0]     last_day;

    assign recip   = DIV100_W'(year) * DIV100_W'(DIV100_MUL);
    assign century = recip[DIV100_SHIFT-1:0] < DIV100_SHIFT'(DIV100_MUL);
    assign leap    = (year[1:0] == 2'd0) && (!century || (recip[DIV100_SHIFT+1:DIV100_SHIFT] == 2'd0));

    always_comb
    begin
        if (month == MONTH_FEB)
        begin
            last_day = leap ? MD_W'(DAYS_FEB_LEAP) : MD_W'(DAYS_FEB);
        end
        else if ((month == MONTH_APR) || (month == MONTH_JUN) ||
                 (month == MONTH_SEP) || (month == MONTH_NOV))
        begin
            last_day = MD_W'(DAYS_SHORT);
        end
        else
        begin
            last_day = MD_W'(DAYS_LONG);
        end
    end

    assign ok = (year <= YEAR_W'(YEAR_MAX)) &&
                (month >= MD_W'(MONTH_MIN)) && (month <= MD_W'(MONTH_MAX)) &&
                (day >= MD_W'(DAY_MIN)) && (day <= last_day);

endmodule

`default_nettype wire

// ----- rtl/drtfl_cell.sv -----
`default_nettype none

module drtfl_cell
    import drtfl_pkg::*;
(
    input  logic              clk,
    input  logic              valid,
    input  cell_ctl_t         ctl,
    input  logic              prev_lt,
    input  logic [KEY_W-1:0]  prev_key,
    input  logic [RATE_W-1:0] prev_rate,
    input  logic              next_le,
    output logic [KEY_W-1:0]  key,
    output logic [RATE_W-1:0] rate,
    output logic              lt,
    output logic              le,
    output logic              eq,
    output logic [RATE_W-1:0] sel_rate
);

    logic [KEY_W-1:0]  key_reg, key_next;
    logic [RATE_W-1:0] rate_reg, rate_next;
    logic [RATE_W-1:0] sel_rate_reg, sel_rate_next;

    assign lt = valid && (key_reg < ctl.key);
    assign le = valid && (key_reg <= ctl.key);
    assign eq = valid && (key_reg == ctl.key);

    // The keys are sorted, so the cells below the probe form a prefix of the row.
    always_comb
    begin
        key_next      = key_reg;
        rate_next     = rate_reg;
        sel_rate_next = sel_rate_reg;
        if (ctl.insert)
        begin
            if (prev_lt && !lt)
            begin
                key_next  = ctl.key;
                rate_next = ctl.rate;
            end
            else if (!prev_lt)
            begin
                key_next  = prev_key;
                rate_next = prev_rate;
            end
        end
        if (ctl.lookup)
        begin
            sel_rate_next = (le && !next_le) ? rate_reg : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        rate_reg     <= rate_next;
        sel_rate_reg <= sel_rate_next;
    end

    assign key      = key_reg;
    assign rate     = rate_reg;
    assign sel_rate = sel_rate_reg;

endmodule

`default_nettype wire

// ----- rtl/drtfl_mult.sv -----
`default_nettype none

module drtfl_mult
    import drtfl_pkg::*;
#(
    parameter int FRACTION_BITS = 16
)
(
    input  logic              clk,
    input  logic              load,
    input  logic [AMT_W-2:0]  amount,
    input  logic [RATE_W-1:0] rate,
    output logic [PROD_W-1:0] product
);

    localparam int SUM_W = PART_W + HALF_W;

    logic [PART_W-1:0] hi_reg, hi_next;
    logic [PART_W-1:0] lo_reg, lo_next;
    logic [SUM_W-1:0]  upper;
    logic [SUM_W-1:0]  lower;
    logic [SUM_W-1:0]  sum;

    always_comb
    begin
        hi_next = hi_reg;
        lo_next = lo_reg;
        if (load)
        begin
            hi_next = PART_W'(amount) * PART_W'(rate[RATE_W-1:HALF_W]);
            lo_next = PART_W'(amount) * PART_W'(rate[HALF_W-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

    assign upper   = SUM_W'(hi_reg) << (HALF_W - FRACTION_BITS);
    assign lower   = SUM_W'(lo_reg >> FRACTION_BITS);
    assign sum     = upper + lower;
    assign product = sum[PROD_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/dated_rate_table_floor_lookup.sv -----
// Stages: an accepted item is registered in stage a, then b, c and d, then in the output register.
// Flow: one item at a time; an item passes the date check, the row of
// compare cells, the rate select and the two-step multiply before the next is taken.
// Reset clears the entry count and the pipeline valid flags; table contents are not
// cleared, since only entries below the count are ever used.
`default_nettype none

module dated_rate_table_floor_lookup
    import drtfl_pkg::*;
#(
    parameter int TABLE_DEPTH   = 64,
    parameter int FRACTION_BITS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,   // year, month, day, rate, amount, zero fill
    input  logic         s_tuser,   // op
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,   // product, rate_used, zero fill
    output logic [2:0]   m_tuser    // status
);

    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int LIMIT_W = AMT_W + FRACTION_BITS;
    localparam logic [LIMIT_W-1:0] AMT_LIMIT = LIMIT_W'(AMOUNT_LIMIT_INT) << FRACTION_BITS;

    localparam int MONTH_LO = YEAR_W;
    localparam int DAY_LO   = MONTH_LO + MD_W;
    localparam int RATE_LO  = DAY_LO + MD_W;
    localparam int AMT_LO   = RATE_LO + RATE_W;
    localparam int OUT_USED = PROD_W + RATE_W;

    logic [YEAR_W-1:0] in_year;
    logic [MD_W-1:0]   in_month;
    logic [MD_W-1:0]   in_day;
    logic              in_ok;
    logic              accept;

    logic              a_valid_reg, a_valid_next;
    logic              a_op_reg;
    logic              a_ok_reg;
    logic [KEY_W-1:0]  a_key_reg;
    logic [RATE_W-1:0] a_rate_reg;
    logic [AMT_W-1:0]  a_amt_reg;

    logic              b_valid_reg;
    status_t           b_status_reg, a_status;
    logic [AMT_W-1:0]  b_amt_reg;

    logic              c_valid_reg;
    status_t           c_status_reg;
    logic [AMT_W-1:0]  c_amt_reg;
    logic [RATE_W-1:0] c_rate_reg, c_rate_next;

    logic              d_valid_reg, d_valid_next;
    status_t           d_status_reg;
    logic [RATE_W-1:0] d_rate_reg;
    logic [PROD_W-1:0] d_product;

    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg;
    logic [PROD_W-1:0] out_product_reg;
    logic [RATE_W-1:0] out_rate_reg;
    logic              out_load;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic              hit;
    logic              full;
    cell_ctl_t         ctl;

    logic [TABLE_DEPTH-1:0] valid_vec;
    logic [TABLE_DEPTH-1:0] lt_vec;
    logic [TABLE_DEPTH-1:0] le_vec;
    logic [TABLE_DEPTH-1:0] eq_vec;
    logic [TABLE_DEPTH:0]   lt_chain;
    logic [TABLE_DEPTH:0]   le_chain;
    logic [KEY_W-1:0]       key_vec  [TABLE_DEPTH];
    logic [RATE_W-1:0]      rate_vec [TABLE_DEPTH];
    logic [RATE_W-1:0]      sel_vec  [TABLE_DEPTH];
    logic [RATE_W-1:0]      sel_any;

    assign in_year  = s_tdata[MONTH_LO-1:0];
    assign in_month = s_tdata[DAY_LO-1:MONTH_LO];
    assign in_day   = s_tdata[RATE_LO-1:DAY_LO];

    drtfl_date_chk u_date_chk
    (
        .year  (in_year),
        .month (in_month),
        .day   (in_day),
        .ok    (in_ok)
    );

    assign s_tready = !(a_valid_reg || b_valid_reg || c_valid_reg || d_valid_reg);
    assign accept   = s_tvalid && s_tready;
    assign a_valid_next = accept;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_op_reg   <= s_tuser;
            a_ok_reg   <= in_ok;
            a_key_reg  <= {in_year, in_month[3:0], in_day[4:0]};
            a_rate_reg <= s_tdata[AMT_LO-1:RATE_LO];
            a_amt_reg  <= s_tdata[AMT_LO+AMT_W-1:AMT_LO];
        end
    end

    assign hit  = |eq_vec;
    assign full = (count_reg == CNT_W'(TABLE_DEPTH));

    always_comb
    begin
        if (!a_ok_reg)
        begin
            a_status = ST_BAD_DATE;
        end
        else if (a_op_reg == OP_LOAD)
        begin
            priority if (hit)
                a_status = ST_DUPLICATE;
            else if (full)
                a_status = ST_FULL;
            else
                a_status = ST_STORED;
        end
        else
        begin
            priority if (a_amt_reg[AMT_W-1])
                a_status = ST_NEGATIVE;
            else if (LIMIT_W'(a_amt_reg) > AMT_LIMIT)
                a_status = ST_TOO_LARGE;
            else if (!le_vec[0])
                a_status = ST_NO_RATE;
            else
                a_status = ST_CONVERTED;
        end
    end

    assign ctl.key    = a_key_reg;
    assign ctl.rate   = a_rate_reg;
    assign ctl.insert = a_valid_reg && (a_status == ST_STORED);
    assign ctl.lookup = a_valid_reg && (a_op_reg == OP_QUERY);

    assign count_next = ctl.insert ? count_reg + CNT_W'(1) : count_reg;

    assign lt_chain[0]           = 1'b1;
    assign le_chain[TABLE_DEPTH] = 1'b0;

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        logic [KEY_W-1:0]  prev_key;
        logic [RATE_W-1:0] prev_rate;

        if (i == 0)
        begin : g_head
            assign prev_key  = '0;
            assign prev_rate = '0;
        end
        else
        begin : g_body
            assign prev_key  = key_vec[i-1];
            assign prev_rate = rate_vec[i-1];
        end

        assign valid_vec[i]  = CNT_W'(i) < count_reg;
        assign lt_chain[i+1] = lt_vec[i];
        assign le_chain[i]   = le_vec[i];

        drtfl_cell u_cell
        (
            .clk       (clk),
            .valid     (valid_vec[i]),
            .ctl       (ctl),
            .prev_lt   (lt_chain[i]),
            .prev_key  (prev_key),
            .prev_rate (prev_rate),
            .next_le   (le_chain[i+1]),
            .key       (key_vec[i]),
            .rate      (rate_vec[i]),
            .lt        (lt_vec[i]),
            .le        (le_vec[i]),
            .eq        (eq_vec[i]),
            .sel_rate  (sel_vec[i])
        );
    end

    always_comb
    begin
        sel_any = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            sel_any = sel_any | sel_vec[i];
        end
        c_rate_next = (b_status_reg == ST_CONVERTED) ? sel_any : '0;
    end

    always_ff @(posedge clk)
    begin
        if (a_valid_reg)
        begin
            b_status_reg <= a_status;
            b_amt_reg    <= a_amt_reg;
        end
        if (b_valid_reg)
        begin
            c_status_reg <= b_status_reg;
            c_amt_reg    <= b_amt_reg;
            c_rate_reg   <= c_rate_next;
        end
        if (c_valid_reg)
        begin
            d_status_reg <= c_status_reg;
            d_rate_reg   <= c_rate_reg;
        end
        if (out_load)
        begin
            out_status_reg  <= d_status_reg;
            out_product_reg <= d_product;
            out_rate_reg    <= d_rate_reg;
        end
    end

    drtfl_mult #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_mult
    (
        .clk     (clk),
        .load    (c_valid_reg),
        .amount  (c_amt_reg[AMT_W-2:0]),
        .rate    (c_rate_reg),
        .product (d_product)
    );

    assign out_load       = d_valid_reg && (!out_valid_reg || m_tready);
    assign d_valid_next   = c_valid_reg || (d_valid_reg && !out_load);
    assign out_valid_next = out_load || (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            d_valid_reg   <= d_valid_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {(112 - OUT_USED)'(0), out_rate_reg, out_product_reg};

endmodule

`default_nettype wire
